// ----- rtl/i2p_pkg.sv -----
// Shared types, character codes and classification functions of the infix to postfix converter.
package i2p_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] PREC_LOW  = 2'd1;
    localparam logic [1:0] PREC_HIGH = 2'd2;
    localparam logic [1:0] PREC_NONE = 2'd0;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNMATCHED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        status_t    status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic       valid;
        result_t    res;
    } emit_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] wdata;
    } stack_ctl_t;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = PREC_NONE;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = PREC_LOW;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = PREC_HIGH;
        end
        return p;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

// ----- rtl/i2p_stack.sv -----
// Operator stack: memory with one write port and one read port, a registered top-of-stack read and a count.
module i2p_stack #(
    parameter int STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  i2p_pkg::stack_ctl_t              ctl,
    output logic [7:0]                       top,
    output logic [$clog2(STACK_DEPTH+1)-1:0] count
);

    localparam int AddrW = $clog2(STACK_DEPTH);
    localparam int CntW  = $clog2(STACK_DEPTH + 1);

    logic [7:0]      mem_reg [STACK_DEPTH];
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic [AddrW-1:0] raddr;
    logic [7:0]      rdata_reg;
    logic            bypass_reg;
    logic [7:0]      bypass_data_reg;

    always_comb begin
        count_next = count_reg;
        if (ctl.clear) begin
            count_next = '0;
        end else if (ctl.push) begin
            count_next = count_reg + CntW'(1);
        end else if (ctl.pop) begin
            count_next = count_reg - CntW'(1);
        end
    end

    // The read address follows the new top, so the new top is registered and ready in the following cycle.
    assign raddr = AddrW'(count_next - CntW'(1));

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem_reg[count_reg[AddrW-1:0]] <= ctl.wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            bypass_reg <= ctl.push;
        end
        bypass_data_reg <= ctl.wdata;
    end

    // A freshly pushed entry is read through the bypass since the memory returns old data.
    assign top   = bypass_reg ? bypass_data_reg : rdata_reg;
    assign count = count_reg;

endmodule

// ----- rtl/i2p_seq.sv -----
// Sequencer: handles one character, drives the stack and the shared precedence compare.
module i2p_seq #(
    parameter int STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_ch,
    input  logic                             in_end,
    input  logic                             out_free,
    output i2p_pkg::emit_t                   emit,
    output i2p_pkg::stack_ctl_t              ctl,
    input  logic [7:0]                       top,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] count
);

    localparam int CntW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_POP_OP,
        ST_POP_PAR,
        ST_FLUSH,
        ST_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [7:0]      ch_reg;
    logic            end_reg;
    logic            err_reg, err_next;
    logic            pend_valid_reg, pend_valid_next;
    i2p_pkg::result_t pend_reg, pend_next;

    logic            empty, full, top_wins, gen_ok, gen_req;
    i2p_pkg::result_t gen;
    i2p_pkg::stack_ctl_t ctl_raw;

    assign empty    = (count == '0);
    assign full     = (count == CntW'(STACK_DEPTH));
    // The one compare unit: precedence on top against that of the held character.
    assign top_wins = i2p_pkg::prec_of(top) >= i2p_pkg::prec_of(ch_reg);
    assign gen_ok   = !pend_valid_reg || out_free;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        err_next        = err_reg;
        gen_req         = 1'b0;
        gen             = '{out_char: top, has_char: 1'b1,
                            status: i2p_pkg::STATUS_OK, last: 1'b0};
        ctl_raw         = '{push: 1'b0, pop: 1'b0, clear: 1'b0, wdata: ch_reg};
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        emit            = '{valid: 1'b0, res: pend_reg};
        ctl             = '{push: 1'b0, pop: 1'b0, clear: 1'b0, wdata: ch_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR: begin
                state_next = ST_FLUSH;
                if (!err_reg && !i2p_pkg::is_blank(ch_reg)) begin
                    if (i2p_pkg::is_alnum(ch_reg)) begin
                        gen_req      = 1'b1;
                        gen.out_char = ch_reg;
                    end else if (ch_reg == i2p_pkg::CH_RPAREN) begin
                        state_next = ST_POP_PAR;
                    end else if (ch_reg == i2p_pkg::CH_LPAREN) begin
                        if (full) begin
                            gen_req      = 1'b1;
                            gen.out_char = 8'h00;
                            gen.has_char = 1'b0;
                            gen.status   = i2p_pkg::STATUS_OVERFLOW;
                            err_next     = 1'b1;
                        end else begin
                            ctl_raw.push = 1'b1;
                        end
                    end else begin
                        state_next = ST_POP_OP;
                    end
                end
            end
            ST_POP_OP: begin
                if (!empty && top_wins) begin
                    gen_req     = 1'b1;
                    ctl_raw.pop = 1'b1;
                end else begin
                    state_next = ST_FLUSH;
                    if (full) begin
                        gen_req      = 1'b1;
                        gen.out_char = 8'h00;
                        gen.has_char = 1'b0;
                        gen.status   = i2p_pkg::STATUS_OVERFLOW;
                        err_next     = 1'b1;
                    end else begin
                        ctl_raw.push = 1'b1;
                    end
                end
            end
            ST_POP_PAR: begin
                if (!empty && top != i2p_pkg::CH_LPAREN) begin
                    gen_req     = 1'b1;
                    ctl_raw.pop = 1'b1;
                end else if (!empty) begin
                    ctl_raw.pop = 1'b1;
                    state_next  = ST_FLUSH;
                end else begin
                    gen_req      = 1'b1;
                    gen.out_char = 8'h00;
                    gen.has_char = 1'b0;
                    gen.status   = i2p_pkg::STATUS_UNMATCHED;
                    err_next     = 1'b1;
                    state_next   = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!end_reg) begin
                    state_next = ST_FIN;
                end else if (!err_reg && !empty) begin
                    gen_req     = 1'b1;
                    ctl_raw.pop = 1'b1;
                end else begin
                    ctl_raw.clear = 1'b1;
                    err_next      = 1'b0;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                // The held result goes out here, marked last at the end of an expression.
                if (end_reg || pend_valid_reg) begin
                    if (out_free) begin
                        emit.valid    = 1'b1;
                        emit.res.last = end_reg;
                        if (!pend_valid_reg) begin
                            emit.res = '{out_char: 8'h00, has_char: 1'b0,
                                         status: i2p_pkg::STATUS_OK, last: 1'b1};
                        end
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg != ST_FIN) begin
            if (gen_req && !gen_ok) begin
                // Hold everything until the result slot frees up.
                state_next = state_reg;
                err_next   = err_reg;
            end else begin
                ctl = ctl_raw;
                if (gen_req) begin
                    emit.valid      = pend_valid_reg;
                    emit.res.last   = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_next       = gen;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
        end
        pend_reg <= pend_next;
        if (in_valid && in_ready) begin
            ch_reg  <= in_ch;
            end_reg <= in_end;
        end
    end

endmodule

// ----- rtl/infix_to_postfix_converter_top.sv -----
// Top level of the infix to postfix converter: sequencer, operator stack and output register.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata = ch, s_tlast = end_of_expr
//  m_       out  m_tvalid/m_tready  m_tdata = out_char, m_tuser = {status, has_char},
//                                   m_tlast = last
//
// An operand, a blank or '(' passes IDLE, CHAR, FLUSH and FIN; an operator also passes POP_OP
// and ')' POP_PAR, which like FLUSH handle one stack entry a cycle while results can go out.
// Each result is held back one step so that the final one can carry last.
// aresetn is synchronous and empties the stack; the stack memory itself is not cleared.
// A stalled m_ side holds the sequencer only when a new result has nowhere to go.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [2:0]  m_tuser,   // [0] has_char, [2:1] status
    output logic        m_tlast
);

    localparam int CntW = $clog2(STACK_DEPTH + 1);

    i2p_pkg::emit_t      emit;
    i2p_pkg::stack_ctl_t ctl;
    logic [7:0]          top;
    logic [CntW-1:0]     count;
    logic                out_free;

    logic                m_valid_reg;
    i2p_pkg::result_t    m_res_reg;

    assign out_free = !m_valid_reg || m_tready;

    i2p_seq #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ch    (s_tdata),
        .in_end   (s_tlast),
        .out_free (out_free),
        .emit     (emit),
        .ctl      (ctl),
        .top      (top),
        .count    (count)
    );

    i2p_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .top     (top),
        .count   (count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit.valid) begin
            m_res_reg <= emit.res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.out_char;
    assign m_tuser  = {m_res_reg.status, m_res_reg.has_char};
    assign m_tlast  = m_res_reg.last;

    // An empty beat that is not an error is only ever the end marker.
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && m_tuser[2:1] == i2p_pkg::STATUS_OK |-> m_tlast)
        else $error("empty beat without last");

    // Error beats never carry a character.
    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] != i2p_pkg::STATUS_OK |-> !m_tuser[0])
        else $error("error beat carries a character");

    // The stack never holds more than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CntW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A new beat is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> out_free)
        else $error("result register overwritten");

endmodule
